// File: hw/rtl/lfc_pkg.sv
// Shared constants and types for the line FIR convolver.
`timescale 1ns / 1ps
`default_nettype none
package lfc_pkg;

	localparam int MAX_TAPS  = 16;
	localparam int COEF_FRAC = 12;

	localparam int COEF_W    = 16;
	localparam int PIX_W     = 8;
	localparam int TAPCFG_W  = 5;
	localparam int IDX_IN_W  = 4;
	localparam int TAP_IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CNT_W     = $clog2(MAX_TAPS + 1);
	localparam int PROD_W    = COEF_W + PIX_W + 1;
	localparam int SUM_W     = PROD_W + TAP_IDX_W;
	localparam int MAG_W     = SUM_W - COEF_FRAC;

	localparam logic [TAPCFG_W-1:0] TAP_RESET = TAPCFG_W'(1);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	// coefficient broadcast to every cell
	typedef struct packed {
		logic                     act;
		logic signed [COEF_W-1:0] coef;
	} bcast_t;

	// partial sum travelling down the chain
	typedef struct packed {
		logic                    tok;
		logic signed [SUM_W-1:0] psum;
	} link_t;

	// sequencer controls toward the datapath
	typedef struct packed {
		logic             start;
		logic             shift_en;
		logic [PIX_W-1:0] shift_pix;
		logic             load_out;
	} ctrl_t;

endpackage
`default_nettype wire

// File: hw/rtl/lfc_cell.sv
// One window cell: holds one pixel and adds its weighted term to a passing partial sum.
`timescale 1ns / 1ps
`default_nettype none
module lfc_cell (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        shift_en,
	input  wire logic [lfc_pkg::PIX_W-1:0]   pix_in,
	output logic      [lfc_pkg::PIX_W-1:0]   pix_out,
	input  wire lfc_pkg::bcast_t             bc,
	input  wire lfc_pkg::link_t              link_in,
	output lfc_pkg::link_t                   link_out
);

	logic [lfc_pkg::PIX_W-1:0]         pix_q;
	logic                              tok_q;
	logic signed [lfc_pkg::SUM_W-1:0]  psum_q;
	logic signed [lfc_pkg::PROD_W-1:0] prod;
	logic signed [lfc_pkg::SUM_W-1:0]  term;

	assign prod = $signed({1'b0, pix_q}) * bc.coef;
	assign term = bc.act ? lfc_pkg::SUM_W'(prod) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
			tok_q <= 1'b0;
		end else begin
			tok_q <= link_in.tok;
			if (shift_en) begin
				pix_q <= pix_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (link_in.tok) begin
			psum_q <= link_in.psum + term;
		end
	end

	assign pix_out       = pix_q;
	assign link_out.tok  = tok_q;
	assign link_out.psum = psum_q;

endmodule
`default_nettype wire

// File: hw/rtl/lfc_ctrl.sv
// Sequencer: tap count register, line count, coefficient memory and sweep control.
`timescale 1ns / 1ps
`default_nettype none
module lfc_ctrl (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic        [lfc_pkg::TAPCFG_W-1:0] tap_count,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                operation,
	input  wire logic        [lfc_pkg::IDX_IN_W-1:0] tap_index,
	input  wire logic signed [lfc_pkg::COEF_W-1:0]   coefficient,
	input  wire logic        [lfc_pkg::PIX_W-1:0]    pixel,
	input  wire logic                                line_start,
	input  wire logic                                last_tok,
	input  wire logic                                out_free,
	output lfc_pkg::bcast_t                          bc,
	output lfc_pkg::ctrl_t                           ctl
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]                          state_q;
	logic [lfc_pkg::TAPCFG_W-1:0]        tap_count_q;
	logic [lfc_pkg::CNT_W-1:0]           cnt_q;
	logic [lfc_pkg::CNT_W-1:0]           taps_q;
	logic [lfc_pkg::CNT_W-1:0]           step_q;
	logic [lfc_pkg::PIX_W-1:0]           pend_pix_q;
	logic                                start_q;
	logic                                act_q;
	logic signed [lfc_pkg::COEF_W-1:0]   coef_q;
	logic signed [lfc_pkg::COEF_W-1:0]   coef_mem [lfc_pkg::MAX_TAPS];

	logic                                accept;
	logic                                pix_acc;
	logic                                emit;
	logic [lfc_pkg::CNT_W-1:0]           taps_eff;
	logic [lfc_pkg::CNT_W-1:0]           cnt_next;
	logic [lfc_pkg::CNT_W-1:0]           rd_diff;
	logic [lfc_pkg::TAP_IDX_W-1:0]       rd_addr;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign pix_acc   = accept && (operation == lfc_pkg::OP_PIXEL);

	always_comb begin
		if (int'(tap_count_q) > lfc_pkg::MAX_TAPS) begin
			taps_eff = lfc_pkg::CNT_W'(lfc_pkg::MAX_TAPS);
		end else begin
			taps_eff = lfc_pkg::CNT_W'(tap_count_q);
		end
		cnt_next = line_start ? '0 : cnt_q;
		emit     = (cnt_next >= taps_eff);
		rd_diff  = taps_q - lfc_pkg::CNT_W'(1) - step_q;
		rd_addr  = rd_diff[lfc_pkg::TAP_IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tap_count_q <= lfc_pkg::TAP_RESET;
			cnt_q       <= '0;
			taps_q      <= '0;
			step_q      <= '0;
			start_q     <= 1'b0;
			act_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tap_count_q <= tap_count;
			end
			start_q <= (state_q == ST_RUN) && (step_q == '0);
			act_q   <= (state_q == ST_RUN) && (step_q < taps_q);
			case (state_q)
				ST_IDLE: begin
					if (pix_acc) begin
						if (int'(cnt_next) < lfc_pkg::MAX_TAPS) begin
							cnt_q <= cnt_next + lfc_pkg::CNT_W'(1);
						end else begin
							cnt_q <= cnt_next;
						end
						if (emit) begin
							state_q <= ST_RUN;
							taps_q  <= taps_eff;
							step_q  <= '0;
						end
					end
				end
				ST_RUN: begin
					if (int'(step_q) < lfc_pkg::MAX_TAPS) begin
						step_q <= step_q + lfc_pkg::CNT_W'(1);
					end
					if (last_tok) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc && emit) begin
			pend_pix_q <= pixel;
		end
		if (accept && (operation == lfc_pkg::OP_LOAD) &&
		    (int'(tap_index) < lfc_pkg::MAX_TAPS)) begin
			coef_mem[lfc_pkg::TAP_IDX_W'(tap_index)] <= coefficient;
		end
		coef_q <= coef_mem[rd_addr];
	end

	assign bc.act        = act_q;
	assign bc.coef       = coef_q;
	assign ctl.start     = start_q;
	assign ctl.shift_en  = (pix_acc && !emit) || ((state_q == ST_RUN) && last_tok);
	assign ctl.shift_pix = (state_q == ST_RUN) ? pend_pix_q : pixel;
	assign ctl.load_out  = (state_q == ST_DRAIN) && out_free;

endmodule
`default_nettype wire

// File: hw/rtl/line_fir_convolver_core.sv
// Top level of the line FIR convolver: cell chain, rounding stage and output register.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, tap_count) sets the number of taps in use;
//   cfg_ready is always high. Write it only while the block is idle.
//   Input beats carry either a coefficient load (operation 0) or a pixel
//   (operation 1, line_start on the first pixel of a line).
//   Loads and pixels that do not yet complete a window never stall the input.
//   A pixel that completes a window starts a sweep: a partial sum walks the
//   chain of MAX_TAPS cells, one cell per cycle, one MAC per cell. The result
//   beat shows on out_valid once the sweep has passed the chain, the rounding
//   stage and the output register, and in_stall stays high for the whole sweep,
//   so no new input is taken until the result register has been loaded.
//   out_stall holds the result register; the sweep then waits in its final
//   step and keeps in_stall high until the result register is free.
//   Reset (arst_n low) clears the window, the line count and the valid flags,
//   and sets the tap count to 1. Coefficients must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none
module line_fir_convolver_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic        [lfc_pkg::TAPCFG_W-1:0] tap_count,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                operation,
	input  wire logic        [lfc_pkg::IDX_IN_W-1:0] tap_index,
	input  wire logic signed [lfc_pkg::COEF_W-1:0]   coefficient,
	input  wire logic        [lfc_pkg::PIX_W-1:0]    pixel,
	input  wire logic                                line_start,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic             [lfc_pkg::PIX_W-1:0]    filtered_pixel,
	output logic                                     out_of_range
);

	localparam logic [lfc_pkg::SUM_W-1:0] HALF =
		lfc_pkg::SUM_W'(1) << (lfc_pkg::COEF_FRAC - 1);

	lfc_pkg::bcast_t                   bc;
	lfc_pkg::ctrl_t                    ctl;
	lfc_pkg::link_t                    links [lfc_pkg::MAX_TAPS + 1];
	logic [lfc_pkg::PIX_W-1:0]         pix_w [lfc_pkg::MAX_TAPS];

	logic                              out_free;
	logic                              out_valid_q;
	logic [lfc_pkg::PIX_W-1:0]         filt_q;
	logic                              oor_q;

	logic signed [lfc_pkg::SUM_W-1:0]  psum_last;
	logic signed [lfc_pkg::SUM_W-1:0]  psum_neg;
	logic [lfc_pkg::SUM_W-1:0]         abs_sum;
	logic [lfc_pkg::SUM_W-1:0]         mag_full;
	logic [lfc_pkg::MAG_W-1:0]         mag_s1;
	logic                              pos_s1;
	logic [lfc_pkg::PIX_W-1:0]         filt_d;
	logic                              oor_d;

	assign out_free = !out_valid_q || !out_stall;

	lfc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.tap_count  (tap_count),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.tap_index  (tap_index),
		.coefficient(coefficient),
		.pixel      (pixel),
		.line_start (line_start),
		.last_tok   (links[lfc_pkg::MAX_TAPS].tok),
		.out_free   (out_free),
		.bc         (bc),
		.ctl        (ctl)
	);

	assign links[0].tok  = ctl.start;
	assign links[0].psum = '0;

	for (genvar j = 0; j < lfc_pkg::MAX_TAPS; j++) begin : g_cell
		logic [lfc_pkg::PIX_W-1:0] pix_in;
		if (j == 0) begin : g_head
			assign pix_in = ctl.shift_pix;
		end else begin : g_body
			assign pix_in = pix_w[j-1];
		end
		lfc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift_en(ctl.shift_en),
			.pix_in  (pix_in),
			.pix_out (pix_w[j]),
			.bc      (bc),
			.link_in (links[j]),
			.link_out(links[j+1])
		);
	end

	// round half away from zero, then drop the fraction
	always_comb begin
		psum_last = links[lfc_pkg::MAX_TAPS].psum;
		psum_neg  = -psum_last;
		abs_sum   = (psum_last > 0) ? psum_last : psum_neg;
		mag_full  = abs_sum + HALF;
	end

	always_ff @(posedge clk) begin
		if (links[lfc_pkg::MAX_TAPS].tok) begin
			mag_s1 <= mag_full[lfc_pkg::SUM_W-1:lfc_pkg::COEF_FRAC];
			pos_s1 <= (psum_last > 0);
		end
	end

	always_comb begin
		if (pos_s1) begin
			filt_d = mag_s1[lfc_pkg::PIX_W-1:0];
			oor_d  = |mag_s1[lfc_pkg::MAG_W-1:lfc_pkg::PIX_W];
		end else begin
			filt_d = (~mag_s1[lfc_pkg::PIX_W-1:0]) + lfc_pkg::PIX_W'(1);
			oor_d  = (mag_s1 != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			filt_q <= filt_d;
			oor_q  <= oor_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign filtered_pixel = filt_q;
	assign out_of_range   = oor_q;

endmodule
`default_nettype wire

// File: hw/rtl/lfc_checker.sv
// Port-level checks for the line FIR convolver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lfc_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                cfg_valid,
	input wire logic                                cfg_ready,
	input wire logic        [lfc_pkg::TAPCFG_W-1:0] tap_count,
	input wire logic                                in_valid,
	input wire logic                                in_stall,
	input wire logic                                operation,
	input wire logic        [lfc_pkg::IDX_IN_W-1:0] tap_index,
	input wire logic signed [lfc_pkg::COEF_W-1:0]   coefficient,
	input wire logic        [lfc_pkg::PIX_W-1:0]    pixel,
	input wire logic                                line_start,
	input wire logic                                out_valid,
	input wire logic                                out_stall,
	input wire logic        [lfc_pkg::PIX_W-1:0]    filtered_pixel,
	input wire logic                                out_of_range
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(filtered_pixel) &&
		$stable(out_of_range))
		else $error("result beat changed while stalled");

	// coefficient loads never stall the input
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (operation == lfc_pkg::OP_LOAD) |=> !in_stall)
		else $error("stall after coefficient load");

	// results only come out of a sweep
	a_out_from_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a sweep");

	// a sweep does not end at the edge where it starts
	a_sweep_len: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |=> in_stall)
		else $error("sweep ended too early");

endmodule

bind line_fir_convolver_core lfc_checker u_lfc_checker (.*);
`default_nettype wire
